/* rtl/core/bldc_hcc_pkg.sv */
// Shared types, register codes and six-step commutation tables for the hall commutation controller.
package bldc_hcc_pkg;

  typedef enum logic [1:0] {
    MODE_STOP    = 2'd0,
    MODE_STARTUP = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_BRAKE   = 2'd3
  } motor_mode_t;

  // Register select is paddr bit 2 (registers at byte addresses 0 and 4).
  localparam logic REG_DIRECTION   = 1'b0;
  localparam logic REG_ERROR_LIMIT = 1'b1;

  localparam int unsigned PADDR_W = 3;

  localparam logic       DIRECTION_RESET   = 1'b1;
  localparam logic [7:0] ERROR_LIMIT_RESET = 8'd200;
  localparam logic [7:0] DISABLE_RESET     = 8'hff;
  localparam logic [7:0] PIN_RESET         = 8'h00;

  localparam logic [7:0] STOP_KEEP_MASK  = 8'h88;
  localparam logic [7:0] BRAKE_KEEP_MASK = 8'hf8;
  localparam logic [7:0] BRAKE_LOW_ON    = 8'h70;
  localparam logic [7:0] ALL_DISABLED    = 8'hff;
  localparam logic [7:0] MISMATCH_MAX    = 8'hff;

  // Brake cycle: stop events below BRAKE_START, brake events below BRAKE_IDLE, then one idle.
  localparam logic [3:0] BRAKE_START = 4'd10;
  localparam logic [3:0] BRAKE_IDLE  = 4'd15;

  localparam logic [7:0] EN_FWD   [8] = '{8'hff, 8'hbf, 8'h7f, 8'hbf, 8'hdf, 8'hdf, 8'h7f, 8'hff};
  localparam logic [7:0] LO_FWD   [8] = '{8'h00, 8'h10, 8'h40, 8'h40, 8'h20, 8'h10, 8'h20, 8'h00};
  localparam logic [7:0] KEEP_FWD [8] = '{8'h88, 8'h98, 8'hc8, 8'hc8, 8'ha8, 8'h98, 8'ha8, 8'h88};
  localparam logic [7:0] EN_REV   [8] = '{8'hff, 8'h7f, 8'hdf, 8'hdf, 8'hbf, 8'h7f, 8'hbf, 8'hff};
  localparam logic [7:0] LO_REV   [8] = '{8'h00, 8'h20, 8'h10, 8'h20, 8'h40, 8'h40, 8'h10, 8'h00};
  localparam logic [7:0] KEEP_REV [8] = '{8'h88, 8'ha8, 8'h98, 8'ha8, 8'hc8, 8'hc8, 8'h98, 8'h88};

  localparam logic [2:0] SUCC_FWD [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
  localparam logic [2:0] SUCC_REV [8] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};

endpackage

/* rtl/core/bldc_hall_commutation_controller.sv */
// Top level of the six-step BLDC hall commutation controller.
// Each hall event transfer is processed in the cycle it is accepted: the packed code
// (U weight 4, W weight 2, V weight 1) selects the commutation tables, and the state
// registers and the output register are both loaded at the accepting edge, so the
// result is offered in the next cycle. One event per cycle is sustained while
// out_ready is high; the output register holds a stalled result, and in_ready is
// high whenever it is empty or being emptied. Users must write direction and error
// limit at APB byte addresses 0 and 4 while no event is in flight; not enforced.
module bldc_hall_commutation_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       hall_u,
  input  logic       hall_v,
  input  logic       hall_w,
  input  logic       button_pressed,
  input  logic [1:0] motor_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pwm_disable_mask,
  output logic [7:0] port_pins,
  output logic [2:0] hall_code,
  output logic       hall_error,
  output logic       pwm_start,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [bldc_hcc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic       direction_forward;
  logic [7:0] error_limit;

  logic [2:0] last_code, last_code_next;
  logic [2:0] expected_code, expected_code_next;
  logic [7:0] mismatch_count, mismatch_count_next;
  logic       error_latched, error_latched_next;
  logic       first_start, first_start_next;
  logic [3:0] brake_count, brake_count_next;
  logic [7:0] pin_register, pin_register_next;
  logic [7:0] disable_register, disable_register_next;
  logic       pwm_start_next;

  logic [2:0] code;
  logic       act;
  logic       in_xfer;
  logic       cfg_write;
  bldc_hcc_pkg::motor_mode_t mode;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == bldc_hcc_pkg::REG_ERROR_LIMIT) ? {24'd0, error_limit}
                                                                 : {31'd0, direction_forward};

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_forward <= bldc_hcc_pkg::DIRECTION_RESET;
      error_limit       <= bldc_hcc_pkg::ERROR_LIMIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == bldc_hcc_pkg::REG_DIRECTION) begin
        direction_forward <= pwdata[0];
      end else begin
        error_limit <= pwdata[7:0];
      end
    end
  end

  assign code     = {hall_u, hall_w, hall_v};
  assign mode     = bldc_hcc_pkg::motor_mode_t'(motor_mode);
  assign act      = button_pressed && (code != last_code);
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    last_code_next        = last_code;
    expected_code_next    = expected_code;
    mismatch_count_next   = mismatch_count;
    error_latched_next    = error_latched;
    first_start_next      = first_start;
    brake_count_next      = brake_count;
    pin_register_next     = pin_register;
    disable_register_next = disable_register;
    pwm_start_next        = 1'b0;
    if (act) begin
      unique case (mode)
        bldc_hcc_pkg::MODE_STARTUP, bldc_hcc_pkg::MODE_RUNNING: begin
          if (direction_forward) begin
            disable_register_next = bldc_hcc_pkg::EN_FWD[code];
            pin_register_next = (pin_register & bldc_hcc_pkg::KEEP_FWD[code])
                                | bldc_hcc_pkg::LO_FWD[code];
          end else begin
            disable_register_next = bldc_hcc_pkg::EN_REV[code];
            pin_register_next = (pin_register & bldc_hcc_pkg::KEEP_REV[code])
                                | bldc_hcc_pkg::LO_REV[code];
          end
          if (mode == bldc_hcc_pkg::MODE_STARTUP) begin
            first_start_next = 1'b0;
            pwm_start_next   = first_start;
          end else begin
            first_start_next = 1'b1;
          end
        end
        bldc_hcc_pkg::MODE_BRAKE: begin
          first_start_next = 1'b1;
          if (brake_count < bldc_hcc_pkg::BRAKE_START) begin
            disable_register_next = bldc_hcc_pkg::ALL_DISABLED;
            pin_register_next     = pin_register & bldc_hcc_pkg::STOP_KEEP_MASK;
          end else if (brake_count < bldc_hcc_pkg::BRAKE_IDLE) begin
            disable_register_next = bldc_hcc_pkg::ALL_DISABLED;
            pin_register_next     = (pin_register & bldc_hcc_pkg::BRAKE_KEEP_MASK)
                                    | bldc_hcc_pkg::BRAKE_LOW_ON;
          end
          brake_count_next = brake_count + 4'd1;
        end
        default: begin
          first_start_next      = 1'b1;
          disable_register_next = bldc_hcc_pkg::ALL_DISABLED;
          pin_register_next     = pin_register & bldc_hcc_pkg::STOP_KEEP_MASK;
        end
      endcase

      // Sequence checking and code tracking happen only while running.
      if (mode == bldc_hcc_pkg::MODE_RUNNING) begin
        if (expected_code != code) begin
          if (mismatch_count > error_limit) begin
            error_latched_next = 1'b1;
          end
          if (mismatch_count != bldc_hcc_pkg::MISMATCH_MAX) begin
            mismatch_count_next = mismatch_count + 8'd1;
          end
        end else begin
          mismatch_count_next = 8'd0;
        end
        expected_code_next = direction_forward ? bldc_hcc_pkg::SUCC_FWD[code]
                                               : bldc_hcc_pkg::SUCC_REV[code];
        last_code_next = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_code        <= 3'd0;
      expected_code    <= 3'd0;
      mismatch_count   <= 8'd0;
      error_latched    <= 1'b0;
      first_start      <= 1'b1;
      brake_count      <= 4'd0;
      pin_register     <= bldc_hcc_pkg::PIN_RESET;
      disable_register <= bldc_hcc_pkg::DISABLE_RESET;
    end else if (in_xfer) begin
      last_code        <= last_code_next;
      expected_code    <= expected_code_next;
      mismatch_count   <= mismatch_count_next;
      error_latched    <= error_latched_next;
      first_start      <= first_start_next;
      brake_count      <= brake_count_next;
      pin_register     <= pin_register_next;
      disable_register <= disable_register_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pwm_disable_mask <= disable_register_next;
      port_pins        <= pin_register_next;
      hall_code        <= code;
      hall_error       <= error_latched_next;
      pwm_start        <= pwm_start_next;
    end
  end

endmodule

/* rtl/core/bldc_hcc_checker.sv */
// Port-level checker for the hall commutation controller, bound to the top level.
module bldc_hcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pwm_disable_mask,
  input logic [7:0] port_pins,
  input logic [2:0] hall_code,
  input logic       hall_error,
  input logic       pwm_start
);

  logic error_seen;

  // Remembers whether any delivered result has shown the error flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen <= 1'b0;
    end else if (out_valid && out_ready && hall_error) begin
      error_seen <= 1'b1;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_seen |-> hall_error)
    else $error("hall error flag dropped after it was reported");

  a_high_side_pins_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> port_pins[2:0] == 3'd0)
    else $error("high-side port bits driven in a result");

  a_input_makes_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted hall event produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_disable_mask) && $stable(port_pins)
      && $stable(hall_code) && $stable(hall_error) && $stable(pwm_start))
    else $error("stalled result changed before its transfer");

endmodule

bind bldc_hall_commutation_controller bldc_hcc_checker u_bldc_hcc_checker (.*);
